// ===== rtl/core/grid_first_fit_placer_macros.svh =====
// ----------------------------------------------------------------------------
// Grid placer assertion macros
// Shorthand for the concurrent checks used by the grid placer checker.
// ----------------------------------------------------------------------------
`ifndef GRID_FIRST_FIT_PLACER_MACROS_SVH
`define GRID_FIRST_FIT_PLACER_MACROS_SVH

// A check that is switched off while reset is high.
`define GFFP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("grid placer check failed");

// A check that also holds across reset.
`define GFFP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("grid placer check failed");

`endif

// ===== rtl/core/gffp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer package
// Field widths, default sizes, operation codes and controller types.
// ----------------------------------------------------------------------------
package gffp_pkg;

   localparam int PAGES_DEF = 8;
   localparam int COLS_DEF  = 8;
   localparam int ROWS_DEF  = 8;

   localparam int OP_W    = 2;
   localparam int PAGE_W  = 3;
   localparam int COORD_W = 16;
   localparam int SIZE_W  = 4;
   localparam int ID_W    = 16;
   localparam int SLOT_W  = 3;
   localparam int OWNER_W = 17;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_PLACE  = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_CLEAR,
      RSP_PLACE,
      RSP_LOOKUP,
      RSP_MISS
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_COL,
      ST_LOAD,
      ST_SCAN,
      ST_OCC_RD,
      ST_OCC_WR,
      ST_ID_WR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic         load_req;
      logic         clr_start;
      logic         clr_step;
      logic         col_start;
      logic         col_next;
      logic         load_start;
      logic         load_step;
      logic         scan_step;
      logic         wr_start;
      logic         occ_rd;
      logic         occ_wr;
      logic         id_wr;
      logic         lk_rd;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            place_args_ok;
      logic            lookup_in_range;
      logic            clr_last;
      logic            col_fits;
      logic            load_done;
      logic            rd_vld;
      logic            row_fits;
      logic            window_free;
      logic            dr_last;
      logic            dc_last;
      logic            out_free;
   } status_type;

endpackage

// ===== rtl/core/gffp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer request channel
// Valid/ready channel that carries one operation per beat.
// ----------------------------------------------------------------------------
interface gffp_req_if;
   logic                               valid;
   logic                               ready;
   logic [gffp_pkg::OP_W-1:0]          op;
   logic [gffp_pkg::PAGE_W-1:0]        page;
   logic signed [gffp_pkg::COORD_W-1:0] col;
   logic signed [gffp_pkg::COORD_W-1:0] row;
   logic [gffp_pkg::SIZE_W-1:0]        rect_width;
   logic [gffp_pkg::SIZE_W-1:0]        rect_height;
   logic [gffp_pkg::ID_W-1:0]          owner_id;

   modport source (
      output valid, op, page, col, row, rect_width, rect_height, owner_id,
      input  ready
   );
   modport sink (
      input  valid, op, page, col, row, rect_width, rect_height, owner_id,
      output ready
   );
endinterface

// ===== rtl/core/gffp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer response channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface gffp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                ok;
   logic [gffp_pkg::SLOT_W-1:0]         slot_col;
   logic [gffp_pkg::SLOT_W-1:0]         slot_row;
   logic signed [gffp_pkg::OWNER_W-1:0] cell_owner;

   modport source (
      output valid, ok, slot_col, slot_row, cell_owner,
      input  ready
   );
   modport sink (
      input  valid, ok, slot_col, slot_row, cell_owner,
      output ready
   );
endinterface

// ===== rtl/core/gffp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer controller
// Sequences clear, place and lookup operations over the datapath.
// ----------------------------------------------------------------------------
module gffp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gffp_pkg::status_type status,
   output gffp_pkg::cmd_type    cmd
);

   gffp_pkg::state_type    state_ff, state_in;
   gffp_pkg::rsp_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gffp_pkg::ST_INIT;
         kind_ff  <= gffp_pkg::RSP_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         gffp_pkg::ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = gffp_pkg::ST_IDLE;
            end
         end
         gffp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = gffp_pkg::ST_DECODE;
            end
         end
         gffp_pkg::ST_DECODE: begin
            unique case (status.op)
               gffp_pkg::OP_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in      = gffp_pkg::ST_CLEAR;
               end
               gffp_pkg::OP_PLACE: begin
                  if (status.place_args_ok) begin
                     cmd.col_start = 1'b1;
                     state_in      = gffp_pkg::ST_COL;
                  end else begin
                     kind_in  = gffp_pkg::RSP_NONE;
                     state_in = gffp_pkg::ST_RESULT;
                  end
               end
               gffp_pkg::OP_LOOKUP: begin
                  if (status.lookup_in_range) begin
                     cmd.lk_rd = 1'b1;
                     kind_in   = gffp_pkg::RSP_LOOKUP;
                  end else begin
                     kind_in = gffp_pkg::RSP_MISS;
                  end
                  state_in = gffp_pkg::ST_RESULT;
               end
               default: begin
                  kind_in  = gffp_pkg::RSP_NONE;
                  state_in = gffp_pkg::ST_RESULT;
               end
            endcase
         end
         gffp_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               kind_in  = gffp_pkg::RSP_CLEAR;
               state_in = gffp_pkg::ST_RESULT;
            end
         end
         gffp_pkg::ST_COL: begin
            if (status.col_fits) begin
               cmd.load_start = 1'b1;
               state_in       = gffp_pkg::ST_LOAD;
            end else begin
               kind_in  = gffp_pkg::RSP_NONE;
               state_in = gffp_pkg::ST_RESULT;
            end
         end
         gffp_pkg::ST_LOAD: begin
            cmd.load_step = 1'b1;
            if (status.load_done && status.rd_vld) begin
               state_in = gffp_pkg::ST_SCAN;
            end
         end
         gffp_pkg::ST_SCAN: begin
            priority if (!status.row_fits) begin
               cmd.col_next = 1'b1;
               state_in     = gffp_pkg::ST_COL;
            end else if (status.window_free) begin
               cmd.wr_start = 1'b1;
               state_in     = gffp_pkg::ST_OCC_RD;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         gffp_pkg::ST_OCC_RD: begin
            cmd.occ_rd = 1'b1;
            state_in   = gffp_pkg::ST_OCC_WR;
         end
         gffp_pkg::ST_OCC_WR: begin
            cmd.occ_wr = 1'b1;
            state_in   = gffp_pkg::ST_ID_WR;
         end
         gffp_pkg::ST_ID_WR: begin
            cmd.id_wr = 1'b1;
            if (status.dr_last) begin
               if (status.dc_last) begin
                  kind_in  = gffp_pkg::RSP_PLACE;
                  state_in = gffp_pkg::ST_RESULT;
               end else begin
                  state_in = gffp_pkg::ST_OCC_RD;
               end
            end
         end
         gffp_pkg::ST_RESULT: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = gffp_pkg::ST_IDLE;
            end
         end
      endcase
   end

endmodule

// ===== rtl/core/gffp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer datapath
// Occupancy and owner memories, scan counters, window check and result register.
// ----------------------------------------------------------------------------
module gffp_datapath #(
   parameter int PAGES = gffp_pkg::PAGES_DEF,
   parameter int COLS  = gffp_pkg::COLS_DEF,
   parameter int ROWS  = gffp_pkg::ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [gffp_pkg::OP_W-1:0]           req_op,
   input  logic [gffp_pkg::PAGE_W-1:0]         req_page,
   input  logic signed [gffp_pkg::COORD_W-1:0] req_col,
   input  logic signed [gffp_pkg::COORD_W-1:0] req_row,
   input  logic [gffp_pkg::SIZE_W-1:0]         req_rect_width,
   input  logic [gffp_pkg::SIZE_W-1:0]         req_rect_height,
   input  logic [gffp_pkg::ID_W-1:0]           req_owner_id,
   input  gffp_pkg::cmd_type                   cmd,
   output gffp_pkg::status_type                status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_ok,
   output logic [gffp_pkg::SLOT_W-1:0]         rsp_slot_col,
   output logic [gffp_pkg::SLOT_W-1:0]         rsp_slot_row,
   output logic signed [gffp_pkg::OWNER_W-1:0] rsp_cell_owner
);

   localparam int OCC_DEPTH = PAGES * COLS;
   localparam int ID_DEPTH  = OCC_DEPTH * ROWS;
   localparam int OAW       = (OCC_DEPTH > 1) ? $clog2(OCC_DEPTH) : 1;
   localparam int IAW       = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
   localparam int CW        = $clog2(COLS + 1);
   localparam int RW        = $clog2(ROWS + 1);
   localparam int CIW       = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int RIW       = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SW        = ((CW > RW) ? CW : RW) + 5;
   localparam int SZ        = gffp_pkg::SIZE_W;

   // Request fields.
   logic [gffp_pkg::OP_W-1:0]    op_ff;
   logic [gffp_pkg::PAGE_W-1:0]  page_ff;
   logic [gffp_pkg::COORD_W-1:0] col_ff;
   logic [gffp_pkg::COORD_W-1:0] row_ff;
   logic [SZ-1:0]                w_ff;
   logic [SZ-1:0]                h_ff;
   logic [gffp_pkg::ID_W-1:0]    id_ff;

   // Scan and sweep state.
   logic [OAW-1:0]  clr_addr_ff, clr_addr_in;
   logic [CW-1:0]   cur_col_ff, cur_col_in;
   logic [RW-1:0]   cur_row_ff, cur_row_in;
   logic [SZ-1:0]   k_ff, k_in;
   logic [SZ-1:0]   dc_ff, dc_in;
   logic [SZ-1:0]   dr_ff, dr_in;
   logic            rd_vld_ff, rd_vld_in;
   logic [ROWS-1:0] acc_ff, acc_in;

   // Memories.
   logic [ROWS-1:0]           occ_mem [OCC_DEPTH];
   logic [ROWS-1:0]           occ_rdata_ff;
   logic [gffp_pkg::ID_W-1:0] id_mem [ID_DEPTH];
   logic [gffp_pkg::ID_W-1:0] id_rdata_ff;

   logic            occ_re, occ_we, id_re, id_we;
   logic [OAW-1:0]  occ_raddr, occ_waddr;
   logic [ROWS-1:0] occ_wdata;
   logic [IAW-1:0]  id_raddr, id_waddr;
   logic [31:0]     page_base, rd_col, wr_col;
   logic [ROWS-1:0] low_mask, row_mask;

   // Result register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_ok_ff;
   logic [gffp_pkg::SLOT_W-1:0]         rsp_col_ff;
   logic [gffp_pkg::SLOT_W-1:0]         rsp_row_ff;
   logic signed [gffp_pkg::OWNER_W-1:0] rsp_owner_ff;

   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         low_mask[i] = (i < int'(h_ff));
         row_mask[i] = (i >= int'(cur_row_ff)) && (i < int'(cur_row_ff) + int'(h_ff));
      end
   end

   always_comb begin
      page_base = 32'(page_ff) * 32'(COLS);
      wr_col    = 32'(cur_col_ff) + 32'(dc_ff);
      if (cmd.load_step) begin
         rd_col = 32'(cur_col_ff) + 32'(k_ff);
      end else if (cmd.lk_rd) begin
         rd_col = 32'(col_ff[CIW-1:0]);
      end else begin
         rd_col = wr_col;
      end
      occ_raddr = OAW'(page_base + rd_col);
      occ_waddr = cmd.clr_step ? clr_addr_ff : OAW'(page_base + wr_col);
      occ_wdata = cmd.clr_step ? '0 : (occ_rdata_ff | row_mask);
      occ_re    = (cmd.load_step && !status.load_done) || cmd.occ_rd || cmd.lk_rd;
      occ_we    = cmd.clr_step || cmd.occ_wr;
      id_raddr  = IAW'((page_base + 32'(col_ff[CIW-1:0])) * 32'(ROWS)
                       + 32'(row_ff[RIW-1:0]));
      id_waddr  = IAW'((page_base + wr_col) * 32'(ROWS) + 32'(cur_row_ff) + 32'(dr_ff));
      id_re     = cmd.lk_rd;
      id_we     = cmd.id_wr;
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      if (occ_re) begin
         occ_rdata_ff <= occ_mem[occ_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= id_ff;
      end
      if (id_re) begin
         id_rdata_ff <= id_mem[id_raddr];
      end
   end

   always_comb begin
      status.op              = op_ff;
      status.place_args_ok   = (32'(page_ff) < 32'(PAGES)) && (w_ff != '0) && (h_ff != '0);
      status.lookup_in_range = (32'(page_ff) < 32'(PAGES))
                               && !col_ff[gffp_pkg::COORD_W-1]
                               && !row_ff[gffp_pkg::COORD_W-1]
                               && (col_ff < gffp_pkg::COORD_W'(COLS))
                               && (row_ff < gffp_pkg::COORD_W'(ROWS));
      status.clr_last        = (clr_addr_ff == OAW'(OCC_DEPTH - 1));
      status.col_fits        = (SW'(cur_col_ff) + SW'(w_ff)) <= SW'(COLS);
      status.load_done       = (k_ff == w_ff);
      status.rd_vld          = rd_vld_ff;
      status.row_fits        = (SW'(cur_row_ff) + SW'(h_ff)) <= SW'(ROWS);
      status.window_free     = ((acc_ff & low_mask) == '0);
      status.dr_last         = (dr_ff == SZ'(h_ff - 1'b1));
      status.dc_last         = (dc_ff == SZ'(w_ff - 1'b1));
      status.out_free        = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      k_in        = k_ff;
      dc_in       = dc_ff;
      dr_in       = dr_ff;
      rd_vld_in   = rd_vld_ff;
      acc_in      = acc_ff;
      if (cmd.clr_start) begin
         clr_addr_in = '0;
      end else if (cmd.clr_step) begin
         clr_addr_in = OAW'(clr_addr_ff + 1'b1);
      end
      if (cmd.col_start) begin
         cur_col_in = '0;
      end else if (cmd.col_next) begin
         cur_col_in = CW'(cur_col_ff + 1'b1);
      end
      if (cmd.load_start) begin
         k_in       = '0;
         rd_vld_in  = 1'b0;
         acc_in     = '0;
         cur_row_in = '0;
      end else if (cmd.load_step) begin
         if (!status.load_done) begin
            k_in = SZ'(k_ff + 1'b1);
         end
         rd_vld_in = !status.load_done;
         if (rd_vld_ff) begin
            acc_in = acc_ff | occ_rdata_ff;
         end
      end else if (cmd.scan_step) begin
         acc_in     = acc_ff >> 1;
         cur_row_in = RW'(cur_row_ff + 1'b1);
      end
      if (cmd.wr_start) begin
         dc_in = '0;
         dr_in = '0;
      end else if (cmd.id_wr) begin
         if (status.dr_last) begin
            dr_in = '0;
            dc_in = SZ'(dc_ff + 1'b1);
         end else begin
            dr_in = SZ'(dr_ff + 1'b1);
         end
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         k_ff         <= '0;
         dc_ff        <= '0;
         dr_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         k_ff         <= k_in;
         dc_ff        <= dc_in;
         dr_ff        <= dr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.load_req) begin
         op_ff   <= req_op;
         page_ff <= req_page;
         col_ff  <= req_col;
         row_ff  <= req_row;
         w_ff    <= req_rect_width;
         h_ff    <= req_rect_height;
         id_ff   <= req_owner_id;
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= 1'b0;
         rsp_col_ff   <= '0;
         rsp_row_ff   <= '0;
         rsp_owner_ff <= '0;
         unique case (cmd.rsp_kind)
            gffp_pkg::RSP_NONE: begin
            end
            gffp_pkg::RSP_CLEAR: begin
               rsp_ok_ff <= 1'b1;
            end
            gffp_pkg::RSP_PLACE: begin
               rsp_ok_ff  <= 1'b1;
               rsp_col_ff <= gffp_pkg::SLOT_W'(cur_col_ff);
               rsp_row_ff <= gffp_pkg::SLOT_W'(cur_row_ff);
            end
            gffp_pkg::RSP_LOOKUP: begin
               if (occ_rdata_ff[row_ff[RIW-1:0]]) begin
                  rsp_owner_ff <= {1'b0, id_rdata_ff};
               end else begin
                  rsp_owner_ff <= '1;
               end
            end
            gffp_pkg::RSP_MISS: begin
               rsp_owner_ff <= '1;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_slot_col   = rsp_col_ff;
   assign rsp_slot_row   = rsp_row_ff;
   assign rsp_cell_owner = rsp_owner_ff;

endmodule

// ===== rtl/core/grid_first_fit_placer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer
// Paged cell grids with clear, first-fit rectangle place and cell lookup.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; a new request beat is taken as soon as
// the previous one has moved into the response register. After reset the block
// empties the occupancy memory before it takes a request, and a clear empties it
// again. A place visits, in order, every column position where the rectangle
// fits across the grid: it merges the occupancy of the w columns under it, one
// column at a time through the single read port of the occupancy memory, and
// then checks each row offset, up to the one that would run off the bottom. A
// place that searches and finds no room also visits the column position that
// runs off the right edge, and a place that succeeds marks the occupancy and
// writes the owner into each covered cell.
module grid_first_fit_placer #(
   parameter int PAGES = gffp_pkg::PAGES_DEF,
   parameter int COLS  = gffp_pkg::COLS_DEF,
   parameter int ROWS  = gffp_pkg::ROWS_DEF
) (
   input logic        clock,
   input logic        reset,
   gffp_req_if.sink   req_ch,
   gffp_rsp_if.source rsp_ch
);

   gffp_pkg::cmd_type    cmd;
   gffp_pkg::status_type status;
   logic                 req_ready;

   gffp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gffp_datapath #(
      .PAGES (PAGES),
      .COLS  (COLS),
      .ROWS  (ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_ch.op),
      .req_page        (req_ch.page),
      .req_col         (req_ch.col),
      .req_row         (req_ch.row),
      .req_rect_width  (req_ch.rect_width),
      .req_rect_height (req_ch.rect_height),
      .req_owner_id    (req_ch.owner_id),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ok          (rsp_ch.ok),
      .rsp_slot_col    (rsp_ch.slot_col),
      .rsp_slot_row    (rsp_ch.slot_row),
      .rsp_cell_owner  (rsp_ch.cell_owner)
   );

   assign req_ch.ready = req_ready;

endmodule

// ===== rtl/core/gffp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer port checker
// Checks request pacing and response consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "grid_first_fit_placer_macros.svh"

module gffp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_ok,
   input logic [gffp_pkg::SLOT_W-1:0]         rsp_slot_col,
   input logic [gffp_pkg::SLOT_W-1:0]         rsp_slot_row,
   input logic signed [gffp_pkg::OWNER_W-1:0] rsp_cell_owner
);

   // The block works on one request at a time.
   `GFFP_ASSERT(a_one_in_flight, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // A response beat waiting for the sink stays valid and holds its owner and ok fields.
   `GFFP_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cell_owner) && $stable(rsp_ok)))

   // Only a lookup carries an owner, and a lookup never reports ok.
   `GFFP_ASSERT(a_owner_only_lookup, clock, reset, (rsp_valid && rsp_cell_owner != '0) |-> !rsp_ok)

   // A failed or lookup response carries no position.
   `GFFP_ASSERT(a_no_slot_on_fail, clock, reset, (rsp_valid && !rsp_ok) |-> (rsp_slot_col == '0 && rsp_slot_row == '0))

   // No response beat is offered in the cycle after reset.
   `GFFP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

endmodule

bind grid_first_fit_placer gffp_checker u_gffp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_ok         (rsp_ch.ok),
   .rsp_slot_col   (rsp_ch.slot_col),
   .rsp_slot_row   (rsp_ch.slot_row),
   .rsp_cell_owner (rsp_ch.cell_owner)
);

// ===== dv/grid_first_fit_placer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer checker
// Watches the request and response channels, keeps its own copy of the cell
// grids, works out the response to every accepted request and compares each
// response beat, field by field, with the oldest one still pending.
// ----------------------------------------------------------------------------
module grid_first_fit_placer_checker (
   input  logic clock,
   input  logic reset,
   gffp_req_if  req_ch,
   gffp_rsp_if  rsp_ch,
   output int   error_count,
   output int   pending_count
);
   import gffp_pkg::*;

   localparam int PAGES = PAGES_DEF;
   localparam int COLS  = COLS_DEF;
   localparam int ROWS  = ROWS_DEF;

   typedef struct packed {
      logic                      ok;
      logic [SLOT_W-1:0]         slot_col;
      logic [SLOT_W-1:0]         slot_row;
      logic signed [OWNER_W-1:0] cell_owner;
   } placer_result_type;

   logic            cell_taken [PAGES][COLS][ROWS];
   logic [ID_W-1:0] cell_id    [PAGES][COLS][ROWS];

   placer_result_type expected_results [$];
   int                mismatches;

   function automatic void empty_grids();
      for (int p = 0; p < PAGES; p++)
         for (int c = 0; c < COLS; c++)
            for (int r = 0; r < ROWS; r++) begin
               cell_taken[p][c][r] = 1'b0;
               cell_id[p][c][r]    = '0;
            end
   endfunction

   // Applies one request to the grids and returns the response it must give.
   function automatic placer_result_type place_or_lookup(
      logic [OP_W-1:0]           op,
      logic [PAGE_W-1:0]         page,
      logic signed [COORD_W-1:0] col,
      logic signed [COORD_W-1:0] row,
      logic [SIZE_W-1:0]         width,
      logic [SIZE_W-1:0]         height,
      logic [ID_W-1:0]           owner
   );
      placer_result_type res;
      logic              found;
      logic              clear_area;
      res   = '0;
      found = 1'b0;
      case (op)
         OP_CLEAR: begin
            empty_grids();
            res.ok = 1'b1;
         end
         OP_PLACE: begin
            if (page < PAGES && width != 0 && height != 0) begin
               for (int c = 0; !found && c + width <= COLS; c++) begin
                  for (int r = 0; !found && r + height <= ROWS; r++) begin
                     clear_area = 1'b1;
                     for (int dc = 0; dc < width; dc++)
                        for (int dr = 0; dr < height; dr++)
                           if (cell_taken[page][c+dc][r+dr])
                              clear_area = 1'b0;
                     if (clear_area) begin
                        for (int dc = 0; dc < width; dc++)
                           for (int dr = 0; dr < height; dr++) begin
                              cell_taken[page][c+dc][r+dr] = 1'b1;
                              cell_id[page][c+dc][r+dr]    = owner;
                           end
                        res.ok       = 1'b1;
                        res.slot_col = c[SLOT_W-1:0];
                        res.slot_row = r[SLOT_W-1:0];
                        found        = 1'b1;
                     end
                  end
               end
            end
         end
         OP_LOOKUP: begin
            res.cell_owner = '1;
            if (page < PAGES && col >= 0 && col < COLS && row >= 0 && row < ROWS)
               if (cell_taken[page][col][row])
                  res.cell_owner = {1'b0, cell_id[page][col][row]};
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void report_mismatch(string what, placer_result_type want,
                                           placer_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected ok=%0b slot=(%0d,%0d) owner=%0d", $realtime, what,
                  want.ok, want.slot_col, want.slot_row, want.cell_owner);
         $display("%0t: %s: got ok=%0b slot=(%0d,%0d) owner=%0d", $realtime, what,
                  got.ok, got.slot_col, got.slot_row, got.cell_owner);
      end
   endfunction

   always @(posedge clock) begin
      placer_result_type seen;
      placer_result_type want;
      if (reset) begin
         empty_grids();
         expected_results.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(place_or_lookup(req_ch.op, req_ch.page, req_ch.col,
               req_ch.row, req_ch.rect_width, req_ch.rect_height, req_ch.owner_id));
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.ok         = rsp_ch.ok;
            seen.slot_col   = rsp_ch.slot_col;
            seen.slot_row   = rsp_ch.slot_row;
            seen.cell_owner = rsp_ch.cell_owner;
            if (expected_results.size() == 0) begin
               report_mismatch("response beat with nothing pending", '0, seen);
            end else begin
               want = expected_results.pop_front();
               if (seen.ok !== want.ok || seen.slot_col !== want.slot_col ||
                   seen.slot_row !== want.slot_row || seen.cell_owner !== want.cell_owner)
                  report_mismatch("response mismatch", want, seen);
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

// ===== dv/tb_grid_first_fit_placer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid placer testbench
// Drives directed and random clear, place, lookup and unused operations into
// the placer under changing idle and stall patterns, including one long
// response hold-off, and reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_grid_first_fit_placer;
   import gffp_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 400;
   localparam int HOLD_OFF_LEN   = 300;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   stall_pct;
   logic hold_off_armed;
   int   held_cycles;
   int   idle_cycles;
   int   error_count;
   int   pending_count;

   gffp_req_if req_ch ();
   gffp_rsp_if rsp_ch ();

   grid_first_fit_placer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   grid_first_fit_placer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response side: random stalls, and one long hold-off once it is armed.
   initial begin
      held_cycles = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_armed && held_cycles < HOLD_OFF_LEN) begin
            rsp_ch.ready <= 1'b0;
            held_cycles = held_cycles + 1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_grid_first_fit_placer failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(
      input logic [OP_W-1:0]           op,
      input logic [PAGE_W-1:0]         page,
      input logic signed [COORD_W-1:0] col,
      input logic signed [COORD_W-1:0] row,
      input logic [SIZE_W-1:0]         width,
      input logic [SIZE_W-1:0]         height,
      input logic [ID_W-1:0]           owner
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.page        <= page;
      req_ch.col         <= col;
      req_ch.row         <= row;
      req_ch.rect_width  <= width;
      req_ch.rect_height <= height;
      req_ch.owner_id    <= owner;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Mostly small rectangles on two busy pages, so that grids fill up and
   // first fit has to search, with occasional clears to start over.
   task automatic send_random_request();
      int                        pick;
      logic [OP_W-1:0]           op;
      logic [PAGE_W-1:0]         page;
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
      pick   = $urandom_range(99);
      col    = COORD_W'($urandom);
      row    = COORD_W'($urandom);
      width  = SIZE_W'($urandom);
      height = SIZE_W'($urandom);
      page   = ($urandom_range(3) == 0) ? PAGE_W'($urandom) : PAGE_W'($urandom_range(1));
      if (pick < 3)
         op = OP_CLEAR;
      else if (pick < 6)
         op = OP_UNUSED;
      else if (pick < 55)
         op = OP_PLACE;
      else
         op = OP_LOOKUP;
      if (op == OP_PLACE && $urandom_range(9) != 0) begin
         width  = SIZE_W'($urandom_range(1, 4));
         height = SIZE_W'($urandom_range(1, 4));
      end
      if (op == OP_LOOKUP && $urandom_range(6) != 0) begin
         col = COORD_W'($urandom_range(COLS_DEF - 1));
         row = COORD_W'($urandom_range(ROWS_DEF - 1));
      end
      send_request(op, page, col, row, width, height, ID_W'($urandom));
   endtask

   initial begin
      reset          = 1'b1;
      send_idle_pct  = 0;
      stall_pct      = 0;
      hold_off_armed = 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_CLEAR;
      req_ch.page        <= '0;
      req_ch.col         <= '0;
      req_ch.row         <= '0;
      req_ch.rect_width  <= '0;
      req_ch.rect_height <= '0;
      req_ch.owner_id    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_LOOKUP, 3'd0, 16'sd0, 16'sd0, 4'd0, 4'd0, 16'h0000);
      send_request(OP_PLACE,  3'd0, 16'sd0, 16'sd0, 4'd1, 4'd1, 16'hFFFF);
      send_request(OP_LOOKUP, 3'd0, 16'sd0, 16'sd0, 4'd0, 4'd0, 16'h0000);
      send_request(OP_PLACE,  3'd0, 16'sd0, 16'sd0, 4'd8, 4'd8, 16'h1111);
      send_request(OP_PLACE,  3'd7, 16'sd0, 16'sd0, 4'd8, 4'd8, 16'h0000);
      send_request(OP_LOOKUP, 3'd7, 16'sd7, 16'sd7, 4'd0, 4'd0, 16'h0000);
      send_request(OP_PLACE,  3'd2, 16'sd0, 16'sd0, 4'd9, 4'd1, 16'h2222);
      send_request(OP_PLACE,  3'd2, 16'sd0, 16'sd0, 4'd15, 4'd15, 16'h2222);
      send_request(OP_PLACE,  3'd2, 16'sd0, 16'sd0, 4'd0, 4'd3, 16'h3333);
      send_request(OP_PLACE,  3'd2, 16'sd0, 16'sd0, 4'd3, 4'd0, 16'h3333);
      send_request(OP_LOOKUP, 3'd2, 16'sd0, 16'sd0, 4'd0, 4'd0, 16'h0000);
      send_request(OP_LOOKUP, 3'd0, -16'sd1, 16'sd0, 4'd0, 4'd0, 16'h0000);
      send_request(OP_LOOKUP, 3'd0, 16'sd0, -16'sd1, 4'd0, 4'd0, 16'h0000);
      send_request(OP_LOOKUP, 3'd7, 16'sd8, 16'sd0, 4'd0, 4'd0, 16'h0000);
      send_request(OP_LOOKUP, 3'd7, 16'sd0, 16'sd8, 4'd0, 4'd0, 16'h0000);
      send_request(OP_LOOKUP, 3'd7, 16'sh7FFF, 16'sh8000, 4'd0, 4'd0, 16'h0000);
      send_request(OP_LOOKUP, 3'd7, 16'sh8000, 16'sh7FFF, 4'd0, 4'd0, 16'h0000);
      send_request(OP_UNUSED, 3'd7, 16'shFFFF, 16'shFFFF, 4'hF, 4'hF, 16'hFFFF);
      send_request(OP_PLACE,  3'd0, 16'sd0, 16'sd0, 4'd2, 4'd3, 16'h1234);
      send_request(OP_PLACE,  3'd0, 16'sd0, 16'sd0, 4'd7, 4'd8, 16'h5678);
      send_request(OP_LOOKUP, 3'd0, 16'sd1, 16'sd3, 4'd0, 4'd0, 16'h0000);
      send_request(OP_LOOKUP, 3'd0, 16'sd7, 16'sd7, 4'd0, 4'd0, 16'h0000);
      send_request(OP_CLEAR,  3'd5, 16'sd3, 16'sd3, 4'd2, 4'd2, 16'hAAAA);
      send_request(OP_LOOKUP, 3'd0, 16'sd0, 16'sd0, 4'd0, 4'd0, 16'h0000);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               stall_pct      = 0;
               hold_off_armed = 1'b1;
            end
            1: begin
               send_idle_pct = 87;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 87;
            end
            default: begin
               send_idle_pct = 15;
               stall_pct     = 15;
            end
         endcase
         repeat (95) send_random_request();
      end
      send_idle_pct = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("tb_grid_first_fit_placer passed");
      else
         $display("tb_grid_first_fit_placer failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gffp_pkg.sv
rtl/core/gffp_req_if.sv
rtl/core/gffp_rsp_if.sv
rtl/core/gffp_ctrl.sv
rtl/core/gffp_datapath.sv
rtl/core/grid_first_fit_placer.sv
rtl/core/gffp_checker.sv
dv/grid_first_fit_placer_checker.sv
dv/tb_grid_first_fit_placer.sv
